### rtl/core/plkt_pkg.sv
// Shared constants, codes and cell interface types for the peer lease keep-alive timer.
package plkt_pkg;

    localparam int LEASE_W     = 20;
    localparam int CNT_W       = 7;
    localparam int FUNC_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int MASK_W      = 16;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 24;
    localparam int DIV_SHIFT   = 25;
    localparam int RECIP_W     = 26;
    localparam int PROD_W      = LEASE_W + RECIP_W;

    localparam logic [FUNC_W-1:0] FUNC_START    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEARD    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TRANSMIT = 2'd3;

    localparam logic CFG_LOCAL_LEASE   = 1'b0;
    localparam logic CFG_JOIN_INTERVAL = 1'b1;

    localparam logic [LEASE_W-1:0] LOCAL_LEASE_RST   = 20'd10000;
    localparam logic [LEASE_W-1:0] JOIN_INTERVAL_RST = 20'd2500;

    typedef struct packed {
        logic               dec;
        logic               check;
        logic               hear;
        logic [LEASE_W-1:0] lease;
    } t_cell_cmd;

    typedef struct packed {
        logic               due;
        logic [LEASE_W-1:0] min_lease;
        logic [CNT_W-1:0]   count;
    } t_acc;

endpackage

### rtl/core/plkt_cell.sv
// One peer slot: lease, countdown, live and heard marks, plus one stage of the summary chain.
module plkt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plkt_pkg::t_cell_cmd i_cmd,
    input  logic                i_sel,
    input  plkt_pkg::t_acc      i_acc,
    output plkt_pkg::t_acc      o_acc,
    output logic                o_expire
);

    logic                         r_valid;
    logic                         r_heard;
    logic [plkt_pkg::LEASE_W-1:0] r_lease;
    logic [plkt_pkg::LEASE_W-1:0] r_countdown;
    plkt_pkg::t_acc               r_acc;
    plkt_pkg::t_acc               n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_heard <= 1'b0;
        end else if (i_cmd.check && r_valid) begin
            if (r_heard) begin
                r_heard <= 1'b0;
            end else begin
                r_valid <= 1'b0;
            end
        end else if (i_cmd.hear && i_sel) begin
            r_valid <= 1'b1;
            r_heard <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec && r_valid && (r_countdown != '0)) begin
            r_countdown <= r_countdown - plkt_pkg::LEASE_W'(1);
        end else if (i_cmd.check && r_valid && r_heard) begin
            r_countdown <= r_lease;
        end else if (i_cmd.hear && i_sel && !r_valid) begin
            r_lease     <= i_cmd.lease;
            r_countdown <= i_cmd.lease;
        end
    end

    // running summary: any countdown at zero, smallest lease, live count
    always_comb begin
        n_acc.due       = i_acc.due | (r_valid && (r_countdown == '0));
        n_acc.min_lease = (r_valid && (r_lease < i_acc.min_lease)) ? r_lease : i_acc.min_lease;
        n_acc.count     = i_acc.count + plkt_pkg::CNT_W'(r_valid);
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc    = r_acc;
    assign o_expire = i_cmd.check & r_valid & ~r_heard;

endmodule

### rtl/core/peer_lease_keepalive_timer.sv
// Peer lease keep-alive timer: a row of slot cells with a shifting summary chain and a sequencer.
// A result word is registered after apply, a wait while the summary passes down the row, check,
// a second wait and a multiply; input words are taken only in idle, none before the last result
// is registered. The two passes down the row of MAX_PEERS cells (one cell per cycle) set the pace.
// A result word waits in the output register while the next input word is taken.
// Reset (synchronous, active low): all slots free, timers stopped, node countdowns zero,
// registers back to local lease 10000 and join interval 2500.
module peer_lease_keepalive_timer #(
    parameter int MAX_PEERS           = 16,
    parameter int LEASE_EXPIRE_FACTOR = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // func [1:0], peer_slot [5:2], peer_lease [25:6], zero [31:26]
    input  logic [plkt_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // send_join [0], send_keep_alive [1], expired_mask [17:2], peer_count [22:18], zero [23]
    output logic [plkt_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [plkt_pkg::LEASE_W-1:0] i_cfg_data
);

    localparam int WAIT_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam logic [plkt_pkg::RECIP_W-1:0] RECIP =
        plkt_pkg::RECIP_W'(((64'd1 << plkt_pkg::DIV_SHIFT) + 64'(LEASE_EXPIRE_FACTOR) - 64'd1)
                           / 64'(LEASE_EXPIRE_FACTOR));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WAIT2 = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [WAIT_W-1:0]                 r_wait;
    logic [plkt_pkg::FUNC_W-1:0]       r_func;
    logic [plkt_pkg::SLOT_W-1:0]       r_slot;
    logic [plkt_pkg::LEASE_W-1:0]      r_plen;
    logic [plkt_pkg::LEASE_W-1:0]      r_local_lease;
    logic [plkt_pkg::LEASE_W-1:0]      r_join_interval;
    logic [plkt_pkg::LEASE_W-1:0]      r_ka_cd;
    logic [plkt_pkg::LEASE_W-1:0]      r_join_cd;
    logic                              r_sent;
    logic                              r_running;
    logic [plkt_pkg::MASK_W-1:0]       r_mask;
    logic [plkt_pkg::PROD_W-1:0]       r_prod;
    logic                              r_out_valid;
    logic [plkt_pkg::OUT_W-1:0]        r_out_data;

    plkt_pkg::t_cell_cmd               w_cmd;
    plkt_pkg::t_acc                    w_acc [MAX_PEERS+1];
    logic [MAX_PEERS-1:0]              w_sel;
    logic [MAX_PEERS-1:0]              w_expire;
    logic [plkt_pkg::MASK_W-1:0]       w_mask;
    logic                              w_tick_run;
    logic                              w_wait_last;
    logic                              w_fin;
    logic [plkt_pkg::LEASE_W-1:0]      w_q;
    logic [plkt_pkg::LEASE_W-1:0]      w_period;
    logic [plkt_pkg::LEASE_W-1:0]      w_join_reload;
    logic                              w_join_fire;
    logic                              w_ka_fire;
    logic                              w_send_ka;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_tick_run      = (r_func == plkt_pkg::FUNC_TICK) && r_running;
    assign w_wait_last     = (r_wait == WAIT_W'(MAX_PEERS - 1));
    assign w_fin           = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    // cell commands
    always_comb begin
        w_cmd.dec   = (r_state == S_APPLY) && w_tick_run;
        w_cmd.check = (r_state == S_CHECK) && w_tick_run && w_acc[MAX_PEERS].due;
        w_cmd.hear  = (r_state == S_APPLY) && (r_func == plkt_pkg::FUNC_HEARD);
        w_cmd.lease = (r_plen == '0) ? plkt_pkg::LEASE_W'(1) : r_plen;
    end

    assign w_acc[0].due       = 1'b0;
    assign w_acc[0].min_lease = r_local_lease;
    assign w_acc[0].count     = '0;

    genvar g;
    for (g = 0; g < MAX_PEERS; g++) begin : g_cell
        assign w_sel[g] = (7'(r_slot) == 7'(g));
        plkt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_sel    (w_sel[g]),
            .i_acc    (w_acc[g]),
            .o_acc    (w_acc[g+1]),
            .o_expire (w_expire[g])
        );
    end

    for (g = 0; g < plkt_pkg::MASK_W; g++) begin : g_mask
        if (g < MAX_PEERS) begin : g_live
            assign w_mask[g] = w_expire[g];
        end else begin : g_none
            assign w_mask[g] = 1'b0;
        end
    end

    // keep-alive period: min lease / factor by reciprocal multiply
    assign w_q           = r_prod[plkt_pkg::DIV_SHIFT +: plkt_pkg::LEASE_W];
    assign w_period      = (w_q == '0) ? plkt_pkg::LEASE_W'(1) : w_q;
    assign w_join_reload = (r_join_interval == '0) ? plkt_pkg::LEASE_W'(1) : r_join_interval;
    assign w_join_fire   = w_tick_run && (r_join_cd == '0);
    assign w_ka_fire     = w_tick_run && (r_ka_cd == '0);
    assign w_send_ka     = w_ka_fire && !(r_sent || w_join_fire);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_APPLY;
            S_APPLY: n_state = S_WAIT1;
            S_WAIT1: if (w_wait_last) n_state = S_CHECK;
            S_CHECK: n_state = S_WAIT2;
            S_WAIT2: if (w_wait_last) n_state = S_MUL;
            S_MUL:   n_state = S_DONE;
            S_DONE:  if (w_fin) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_WAIT1) || (r_state == S_WAIT2)) begin
                r_wait <= w_wait_last ? '0 : r_wait + WAIT_W'(1);
            end else begin
                r_wait <= '0;
            end
        end
    end

    // input word and datapath registers
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_func <= i_s_axis_tdata[1:0];
            r_slot <= i_s_axis_tdata[5:2];
            r_plen <= i_s_axis_tdata[25:6];
        end
        if (r_state == S_APPLY) begin
            r_mask <= '0;
        end else if (w_cmd.check) begin
            r_mask <= w_mask;
        end
        if (r_state == S_MUL) begin
            r_prod <= plkt_pkg::PROD_W'(w_acc[MAX_PEERS].min_lease) * plkt_pkg::PROD_W'(RECIP);
        end
        if (w_fin) begin
            r_out_data <= {1'b0, plkt_pkg::COUNT_OUT_W'(w_acc[MAX_PEERS].count), r_mask,
                           w_send_ka, w_join_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_lease   <= plkt_pkg::LOCAL_LEASE_RST;
            r_join_interval <= plkt_pkg::JOIN_INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                plkt_pkg::CFG_LOCAL_LEASE:   r_local_lease   <= i_cfg_data;
                plkt_pkg::CFG_JOIN_INTERVAL: r_join_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // node timers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka_cd   <= '0;
            r_join_cd <= '0;
            r_sent    <= 1'b0;
            r_running <= 1'b0;
        end else if ((r_state == S_APPLY) && w_tick_run) begin
            if (r_ka_cd != '0) r_ka_cd <= r_ka_cd - plkt_pkg::LEASE_W'(1);
            if (r_join_cd != '0) r_join_cd <= r_join_cd - plkt_pkg::LEASE_W'(1);
        end else if (w_fin) begin
            case (r_func)
                plkt_pkg::FUNC_START: begin
                    r_running <= 1'b1;
                    r_sent    <= 1'b0;
                    r_join_cd <= w_join_reload;
                    r_ka_cd   <= w_period;
                end
                plkt_pkg::FUNC_TICK: begin
                    if (w_join_fire) begin
                        r_join_cd <= w_join_reload;
                    end
                    // keep-alive clears the sent mark after a join on the same tick
                    if (w_ka_fire) begin
                        r_ka_cd <= w_period;
                        r_sent  <= 1'b0;
                    end else if (w_join_fire) begin
                        r_sent  <= 1'b1;
                    end
                end
                plkt_pkg::FUNC_TRANSMIT: r_sent <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (w_acc[MAX_PEERS].count <= plkt_pkg::CNT_W'(MAX_PEERS)))
        else $error("live peer count above table size");

    a_events_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && !w_tick_run) |=> (o_m_axis_tdata[17:0] == '0))
        else $error("join, keep-alive or expiry outside a running tick");

    a_timers_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && (r_state == S_IDLE)) |-> ((r_ka_cd != '0) && (r_join_cd != '0)))
        else $error("countdown left at zero while running");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT1 || r_state == S_WAIT2) |-> (r_wait <= WAIT_W'(MAX_PEERS - 1)))
        else $error("chain wait counter out of range");

endmodule
